@@ hw/rtl/msgpack_stream_parser_unit_macros.svh @@
// Assertion macros for the MessagePack stream parser.
// Included by the top level; no other dependencies.
`ifndef MSGPACK_STREAM_PARSER_UNIT_MACROS_SVH
`define MSGPACK_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define MSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/msp_pkg.sv @@
// Shared types, codes and helper functions for the MessagePack stream parser.
// No dependencies; used by the interfaces, the count stack and the top level.
package msp_pkg;

    localparam int MAX_NEST   = 8;
    localparam int NEST_DEPTH = MAX_NEST + 1;
    localparam int LVL_W      = 4;
    localparam int IDX_W      = $clog2(NEST_DEPTH);
    localparam int CNT_W      = 33;

    // result kinds
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_SCALAR    = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd2;
    localparam logic [2:0] KIND_STR_START = 3'd3;
    localparam logic [2:0] KIND_OPEN      = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;
    localparam logic [2:0] KIND_IGNORED   = 3'd6;

    // value types
    localparam logic [3:0] VT_NIL    = 4'd0;
    localparam logic [3:0] VT_BOOL   = 4'd1;
    localparam logic [3:0] VT_UINT   = 4'd2;
    localparam logic [3:0] VT_INT    = 4'd3;
    localparam logic [3:0] VT_DOUBLE = 4'd4;
    localparam logic [3:0] VT_STR    = 4'd5;
    localparam logic [3:0] VT_BIN    = 4'd6;
    localparam logic [3:0] VT_MAP    = 4'd7;
    localparam logic [3:0] VT_ARRAY  = 4'd8;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TAG   = 2'd1;
    localparam logic [1:0] ERR_DEPTH = 2'd2;
    localparam logic [1:0] ERR_TRUNC = 2'd3;

    // tags
    localparam logic [7:0] TAG_FIXINT_MAX = 8'h7F;
    localparam logic [7:0] TAG_NEG_FIXINT = 8'hE0;
    localparam logic [7:0] TAG_FIXSTR     = 8'hA0;
    localparam logic [7:0] TAG_FIXMAP     = 8'h80;
    localparam logic [7:0] TAG_FIXARRAY   = 8'h90;
    localparam logic [7:0] TAG_NIL        = 8'hC0;
    localparam logic [7:0] TAG_FALSE      = 8'hC2;
    localparam logic [7:0] TAG_TRUE       = 8'hC3;
    localparam logic [7:0] TAG_BIN8       = 8'hC4;
    localparam logic [7:0] TAG_BIN32      = 8'hC6;
    localparam logic [7:0] TAG_FLOAT32    = 8'hCA;
    localparam logic [7:0] TAG_FLOAT64    = 8'hCB;
    localparam logic [7:0] TAG_UINT8      = 8'hCC;
    localparam logic [7:0] TAG_UINT64     = 8'hCF;
    localparam logic [7:0] TAG_INT8       = 8'hD0;
    localparam logic [7:0] TAG_INT64      = 8'hD3;
    localparam logic [7:0] TAG_STR8       = 8'hD9;
    localparam logic [7:0] TAG_STR32      = 8'hDB;
    localparam logic [7:0] TAG_ARRAY16    = 8'hDC;
    localparam logic [7:0] TAG_ARRAY32    = 8'hDD;
    localparam logic [7:0] TAG_MAP16      = 8'hDE;
    localparam logic [7:0] TAG_MAP32      = 8'hDF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } msp_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  value_type;
        logic [63:0] value_bits;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [3:0]  nest_level;
        logic        top_value_done;
        logic [1:0]  error_code;
    } msp_out_t;

    typedef struct packed {
        logic             complete;
        logic             push;
        logic             clear;
        logic [CNT_W-1:0] children;
    } stk_cmd_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] next_level;
        logic             top_done;
        logic             busy;
    } stk_stat_t;

    function automatic logic [3:0] type_of_tag(input logic [7:0] t);
        logic [3:0] r;
        r = VT_NIL;
        if ((t & 8'hE0) == TAG_FIXSTR || (t >= TAG_STR8 && t <= TAG_STR32)) r = VT_STR;
        else if (t >= TAG_BIN8 && t <= TAG_BIN32) r = VT_BIN;
        else if (t == TAG_FLOAT32 || t == TAG_FLOAT64) r = VT_DOUBLE;
        else if (t >= TAG_UINT8 && t <= TAG_UINT64) r = VT_UINT;
        else if (t >= TAG_INT8 && t <= TAG_INT64) r = VT_INT;
        else if (t == TAG_ARRAY16 || t == TAG_ARRAY32) r = VT_ARRAY;
        else if (t == TAG_MAP16 || t == TAG_MAP32) r = VT_MAP;
        return r;
    endfunction

    // Exact float32 to binary64 widening; subnormals become normals.
    function automatic logic [63:0] widen_f32(input logic [31:0] f);
        logic [63:0] r;
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  p;
        logic [4:0]  k;
        logic [22:0] mn;
        e  = f[30:23];
        m  = f[22:0];
        p  = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (m[i])
                p = 5'(i);
        end
        k  = 5'd23 - p;
        mn = 23'(m << k);
        if (e == 8'hFF)
            r = {f[31], 11'h7FF, m, 29'd0};
        else if (e == 8'd0)
        begin
            if (m == 23'd0)
                r = {f[31], 63'd0};
            else
                r = {f[31], 11'(11'd897 - {6'd0, k}), mn, 29'd0};
        end
        else
            r = {f[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
        return r;
    endfunction

endpackage

@@ hw/rtl/msp_if.sv @@
// Valid/ready channel interfaces for the parser input and result streams.
// Depends on msp_pkg for the payload structs.
interface msp_in_if
    import msp_pkg::*;
();
    logic    valid;
    logic    ready;
    msp_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface msp_out_if
    import msp_pkg::*;
();
    logic     valid;
    logic     ready;
    msp_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/msp_count_stack.sv @@
// Stack of remaining child counts for open maps and arrays.
// Top count in a register, lower levels in a memory with registered reads; uses msp_pkg.
module msp_count_stack
    import msp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stk_cmd_t  cmd,
    output stk_stat_t stat
);

    logic [CNT_W-1:0]      mem [NEST_DEPTH];
    logic [CNT_W-1:0]      rd_reg;
    logic [CNT_W-1:0]      top_cnt_reg, top_cnt_next;
    logic [LVL_W-1:0]      level_reg, level_next;
    logic [NEST_DEPTH-1:0] one_reg, one_next;
    logic                  refill_reg, refill_next;
    logic                  we;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic [LVL_W-1:0]      pop_to;
    logic [LVL_W-1:0]      step_level;
    logic                  top_done;

    // Deepest lower level that stays open once the top closes.
    always_comb
    begin
        pop_to = '0;
        for (int j = 1; j <= NEST_DEPTH; j++)
        begin
            if (LVL_W'(j) < level_reg && !one_reg[j-1])
                pop_to = LVL_W'(j);
        end
    end

    always_comb
    begin
        top_cnt_next = top_cnt_reg;
        level_next   = level_reg;
        one_next     = one_reg;
        refill_next  = 1'b0;
        we           = 1'b0;
        wr_addr      = IDX_W'(level_reg - 1'b1);
        rd_addr      = IDX_W'(pop_to - 1'b1);
        top_done     = 1'b0;
        if (refill_reg)
            top_cnt_next = rd_reg - 1'b1;
        if (cmd.complete)
        begin
            if (level_reg == '0)
                top_done = 1'b1;
            else if (top_cnt_reg != CNT_W'(1))
                top_cnt_next = top_cnt_reg - 1'b1;
            else
            begin
                level_next = pop_to;
                if (pop_to == '0)
                    top_done = 1'b1;
                else
                    refill_next = 1'b1;
            end
        end
        else if (cmd.push)
        begin
            if (level_reg != '0)
            begin
                we                = 1'b1;
                one_next[wr_addr] = (top_cnt_reg == CNT_W'(1));
            end
            top_cnt_next = cmd.children;
            level_next   = level_reg + 1'b1;
        end
        // Depth after this item, before a buffer end wipes the stack.
        step_level = level_next;
        if (cmd.clear)
        begin
            level_next  = '0;
            one_next    = '0;
            refill_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            one_reg     <= '0;
            refill_reg  <= 1'b0;
            top_cnt_reg <= '0;
        end
        else
        begin
            level_reg   <= level_next;
            one_reg     <= one_next;
            refill_reg  <= refill_next;
            top_cnt_reg <= top_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= top_cnt_reg;
        rd_reg <= mem[rd_addr];
    end

    assign stat.level      = level_reg;
    assign stat.next_level = step_level;
    assign stat.top_done   = top_done;
    assign stat.busy       = refill_reg;

endmodule

@@ hw/rtl/msgpack_stream_parser_unit.sv @@
// MessagePack stream parser top level: byte decoder, phase state and result register.
// Depends on msp_pkg, msp_if, msp_count_stack and the assertion macro header.
//
// Usage:
//   in_ch  carries one encoded byte per item (data_byte, buffer_end).
//   out_ch carries exactly one result item per input byte, in order.
//   cfg_we/cfg_wdata write nest_limit (reset 8); write only while idle.
// Output: a registered result appears on out_ch in the cycle after its byte is taken.
// Throughput: one byte per cycle unless out_ch stalls or a stack refill is pending.
//   A byte that closes the top container while a lower container stays open
//   stalls in_ch until the parent count is read back from the stack memory.
// Reset: parser idle, nothing open, no error held, no result pending. The
//   count memory needs no clearing; each entry is written when a deeper level opens.
// Stall: the result register holds while out_ch.ready is low; in_ch.ready is high
//   while no stack refill is pending and the register is empty or emptied this cycle.
// Errors: after an error, bytes give ignored results until a byte with
//   buffer_end, which returns everything to idle.
`include "msgpack_stream_parser_unit_macros.svh"

module msgpack_stream_parser_unit
    import msp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    msp_in_if.sink         in_ch,
    msp_out_if.source      out_ch,
    input  logic           cfg_we,
    input  logic [3:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCALAR,
        PH_LEN,
        PH_COUNT,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_tag_reg, held_tag_next;
    logic [63:0] gather_reg, gather_next;
    logic [31:0] left_reg, left_next;
    logic        err_hold_reg, err_hold_next;
    logic [3:0]  limit_reg;
    logic        out_valid_reg;
    msp_out_t    out_reg, res;

    stk_cmd_t    cmd;
    stk_stat_t   stat;

    logic        accept;
    logic [7:0]  b;
    logic [3:0]  lim;
    logic [63:0] g;
    logic [3:0]  n_bytes;
    phase_t      n_phase;
    logic [1:0]  err;
    logic [3:0]  vt_held;

    msp_count_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign in_ch.ready = !stat.busy && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data.data_byte;
    assign lim         = (limit_reg > 4'(MAX_NEST)) ? 4'(MAX_NEST) : limit_reg;
    assign g           = {gather_reg[55:0], b};
    assign vt_held     = type_of_tag(held_tag_reg);

    // Multi-byte tag: number of bytes that follow and the phase that gathers them.
    always_comb
    begin
        n_bytes = 4'd0;
        n_phase = PH_SCALAR;
        priority if (b >= TAG_BIN8 && b <= TAG_BIN32)
        begin
            n_bytes = 4'(4'd1 << (b - TAG_BIN8));
            n_phase = PH_LEN;
        end
        else if (b >= TAG_STR8 && b <= TAG_STR32)
        begin
            n_bytes = 4'(4'd1 << (b - TAG_STR8));
            n_phase = PH_LEN;
        end
        else if (b == TAG_FLOAT32)
            n_bytes = 4'd4;
        else if (b == TAG_FLOAT64)
            n_bytes = 4'd8;
        else if (b >= TAG_UINT8 && b <= TAG_UINT64)
            n_bytes = 4'(5'd1 << (b - TAG_UINT8));
        else if (b >= TAG_INT8 && b <= TAG_INT64)
            n_bytes = 4'(5'd1 << (b - TAG_INT8));
        else if (b == TAG_ARRAY16 || b == TAG_MAP16)
        begin
            n_bytes = 4'd2;
            n_phase = PH_COUNT;
        end
        else if (b == TAG_ARRAY32 || b == TAG_MAP32)
        begin
            n_bytes = 4'd4;
            n_phase = PH_COUNT;
        end
        else
            n_bytes = 4'd0;
    end

    always_comb
    begin
        res            = '0;
        res.nest_level = stat.level;
        err            = ERR_NONE;
        cmd            = '0;
        phase_next     = phase_reg;
        held_tag_next  = held_tag_reg;
        gather_next    = gather_reg;
        left_next      = left_reg;
        err_hold_next  = err_hold_reg;

        if (err_hold_reg)
        begin
            res.kind       = KIND_IGNORED;
            res.nest_level = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (stat.level > lim)
                        err = ERR_DEPTH;
                    else if (b <= TAG_FIXINT_MAX)
                    begin
                        res.kind       = KIND_SCALAR;
                        res.value_type = VT_UINT;
                        res.value_bits = {56'd0, b};
                        cmd.complete   = 1'b1;
                    end
                    else if (b >= TAG_NEG_FIXINT)
                    begin
                        res.kind       = KIND_SCALAR;
                        res.value_type = VT_INT;
                        res.value_bits = {{56{b[7]}}, b};
                        cmd.complete   = 1'b1;
                    end
                    else if ((b & 8'hE0) == TAG_FIXSTR)
                    begin
                        res.kind       = KIND_STR_START;
                        res.value_type = VT_STR;
                        res.value_bits = {59'd0, b[4:0]};
                        if (b[4:0] == 5'd0)
                            cmd.complete = 1'b1;
                        else
                        begin
                            held_tag_next = b;
                            left_next     = {27'd0, b[4:0]};
                            phase_next    = PH_PAYLOAD;
                        end
                    end
                    else if ((b & 8'hF0) == TAG_FIXMAP || (b & 8'hF0) == TAG_FIXARRAY)
                    begin
                        res.kind       = KIND_OPEN;
                        res.value_type = (b[4]) ? VT_ARRAY : VT_MAP;
                        res.value_bits = {60'd0, b[3:0]};
                        if (b[3:0] == 4'd0)
                            cmd.complete = 1'b1;
                        else
                        begin
                            cmd.push     = 1'b1;
                            cmd.children = b[4] ? {29'd0, b[3:0]} : {28'd0, b[3:0], 1'b0};
                        end
                    end
                    else if (b == TAG_NIL)
                    begin
                        res.kind       = KIND_SCALAR;
                        res.value_type = VT_NIL;
                        cmd.complete   = 1'b1;
                    end
                    else if (b == TAG_FALSE || b == TAG_TRUE)
                    begin
                        res.kind       = KIND_SCALAR;
                        res.value_type = VT_BOOL;
                        res.value_bits = {63'd0, b[0]};
                        cmd.complete   = 1'b1;
                    end
                    else if (n_bytes == 4'd0)
                        err = ERR_TAG;
                    else
                    begin
                        res.kind       = KIND_HEADER;
                        res.value_type = type_of_tag(b);
                        held_tag_next  = b;
                        gather_next    = '0;
                        left_next      = {28'd0, n_bytes};
                        phase_next     = n_phase;
                    end
                end
                PH_PAYLOAD:
                begin
                    res.kind         = KIND_PAYLOAD;
                    res.value_type   = vt_held;
                    res.payload_byte = b;
                    left_next        = left_reg - 1'b1;
                    if (left_reg == 32'd1)
                    begin
                        res.last_payload = 1'b1;
                        phase_next       = PH_IDLE;
                        cmd.complete     = 1'b1;
                    end
                end
                PH_SCALAR, PH_LEN, PH_COUNT:
                begin
                    res.value_type = vt_held;
                    gather_next    = g;
                    left_next      = left_reg - 1'b1;
                    if (left_reg != 32'd1)
                        res.kind = KIND_HEADER;
                    else if (phase_reg == PH_SCALAR)
                    begin
                        phase_next   = PH_IDLE;
                        res.kind     = KIND_SCALAR;
                        cmd.complete = 1'b1;
                        if (held_tag_reg == TAG_FLOAT32)
                            res.value_bits = widen_f32(g[31:0]);
                        else if (held_tag_reg >= TAG_INT8 && held_tag_reg <= TAG_INT64)
                        begin
                            unique case (held_tag_reg[1:0])
                                2'd0: res.value_bits = {{56{g[7]}}, g[7:0]};
                                2'd1: res.value_bits = {{48{g[15]}}, g[15:0]};
                                2'd2: res.value_bits = {{32{g[31]}}, g[31:0]};
                                default: res.value_bits = g;
                            endcase
                        end
                        else
                            res.value_bits = g;
                    end
                    else if (phase_reg == PH_LEN)
                    begin
                        res.kind       = KIND_STR_START;
                        res.value_bits = {32'd0, g[31:0]};
                        if (g[31:0] == 32'd0)
                        begin
                            phase_next   = PH_IDLE;
                            cmd.complete = 1'b1;
                        end
                        else
                        begin
                            left_next  = g[31:0];
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        phase_next     = PH_IDLE;
                        res.kind       = KIND_OPEN;
                        res.value_bits = {32'd0, g[31:0]};
                        if (g[31:0] == 32'd0)
                            cmd.complete = 1'b1;
                        else
                        begin
                            cmd.push     = 1'b1;
                            cmd.children = (vt_held == VT_MAP) ? {g[31:0], 1'b0}
                                                               : {1'b0, g[31:0]};
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            res.top_value_done = stat.top_done;
            if (err == ERR_NONE && in_ch.data.buffer_end
                && (phase_next != PH_IDLE || stat.next_level != '0))
                err = ERR_TRUNC;
            if (err != ERR_NONE)
            begin
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = err;
                res.nest_level = stat.next_level;
                err_hold_next  = 1'b1;
            end
        end

        if (in_ch.data.buffer_end)
        begin
            phase_next    = PH_IDLE;
            held_tag_next = '0;
            gather_next   = '0;
            left_next     = '0;
            err_hold_next = 1'b0;
            cmd.clear     = 1'b1;
        end

        // Only an accepted byte moves the stack.
        if (!accept)
            cmd = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            held_tag_reg  <= '0;
            gather_reg    <= '0;
            left_reg      <= '0;
            err_hold_reg  <= 1'b0;
            limit_reg     <= 4'(MAX_NEST);
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg     <= phase_next;
                held_tag_reg  <= held_tag_next;
                gather_reg    <= gather_next;
                left_reg      <= left_next;
                err_hold_reg  <= err_hold_next;
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    `MSP_ASSERT_IMPLY(a_busy_blocks_input, clk, rst_n, stat.busy, !in_ch.ready,
        "byte taken while stack refill pending")
    `MSP_ASSERT_IMPLY(a_error_has_code, clk, rst_n,
        out_valid_reg && out_reg.kind == KIND_ERROR, out_reg.error_code != ERR_NONE,
        "error result without code")
    `MSP_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && in_ch.data.buffer_end,
        phase_reg == PH_IDLE && stat.level == '0 && !err_hold_reg && !stat.busy,
        "buffer end did not return parser to idle")

endmodule

@@ verif/msgpack_stream_parser_unit_tb.sv @@
// Testbench for msgpack_stream_parser_unit: directed and random MessagePack buffers,
// checked item by item against a local decoder model. Depends on msp_pkg, msp_if and the DUT.
module msgpack_stream_parser_unit_tb;
    import msp_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE, P_SCALAR, P_LEN, P_COUNT, P_PAYLOAD
    } phase_e;

    localparam int CFG_INDEX  = 0;
    localparam int IDLE_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [3:0] cfg_wdata;

    msp_in_if  in_ch();
    msp_out_if out_ch();

    msgpack_stream_parser_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // decoder state
    phase_e      dec_phase;
    logic [7:0]  dec_tag;
    logic [63:0] dec_gather;
    logic [31:0] dec_left;
    logic [32:0] dec_counts [NEST_DEPTH];
    logic [3:0]  dec_level;
    logic        dec_error;
    logic [3:0]  dec_limit;

    msp_out_t    expected_tokens [$];
    logic [7:0]  byte_seq [$];
    int          fail_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void clear_decoder();
        dec_phase  = P_IDLE;
        dec_tag    = '0;
        dec_gather = '0;
        dec_left   = '0;
        dec_level  = '0;
        dec_error  = 1'b0;
        for (int i = 0; i < NEST_DEPTH; i++)
            dec_counts[i] = '0;
    endfunction

    function automatic logic [3:0] tag_type(input logic [7:0] t);
        logic [3:0] r;
        r = VT_NIL;
        if (t[7:5] == 3'b101 || (t >= 8'hD9 && t <= 8'hDB))
            r = VT_STR;
        else if (t >= 8'hC4 && t <= 8'hC6)
            r = VT_BIN;
        else if (t == 8'hCA || t == 8'hCB)
            r = VT_DOUBLE;
        else if (t >= 8'hCC && t <= 8'hCF)
            r = VT_UINT;
        else if (t >= 8'hD0 && t <= 8'hD3)
            r = VT_INT;
        else if (t == 8'hDC || t == 8'hDD)
            r = VT_ARRAY;
        else if (t == 8'hDE || t == 8'hDF)
            r = VT_MAP;
        return r;
    endfunction

    function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
        logic [22:0] m;
        int          shift;
        m = f[22:0];
        shift = 0;
        if (f[30:23] == 8'hFF)
            return {f[31], 11'h7FF, m, 29'd0};
        if (f[30:23] != 8'd0)
            return {f[31], 11'(f[30:23] + 11'd896), m, 29'd0};
        if (m == 23'd0)
            return {f[31], 63'd0};
        // normalize: shift until the hidden bit appears above the fraction
        while (!m[22])
        begin
            m = m << 1;
            shift++;
        end
        m = m << 1;
        return {f[31], 11'(11'd896 - shift), m, 29'd0};
    endfunction

    // Pop finished containers; return 1 when a top-level value completes.
    function automatic logic finish_value();
        int i;
        forever
        begin
            if (dec_level == 0)
                return 1'b1;
            i = (dec_level - 1) % NEST_DEPTH;
            dec_counts[i] = dec_counts[i] - 33'd1;
            if (dec_counts[i] != 0)
                return 1'b0;
            dec_level--;
        end
    endfunction

    function automatic logic open_children(input logic [32:0] n, input logic [3:0] lvl);
        if (n == 0)
            return finish_value();
        dec_counts[lvl % NEST_DEPTH] = n;
        dec_level = 4'(lvl + 1);
        return 1'b0;
    endfunction

    function automatic msp_out_t decode_byte(input logic [7:0] b, input logic last_byte);
        msp_out_t r;
        logic [3:0]  lim;
        logic [3:0]  lvl;
        logic [1:0]  err;
        int          n;
        phase_e      ph;
        r = '0;
        err = ERR_NONE;
        lim = (dec_limit > MAX_NEST) ? 4'(MAX_NEST) : dec_limit;
        lvl = dec_level;
        if (dec_error)
        begin
            if (last_byte)
                clear_decoder();
            r.kind = KIND_IGNORED;
            return r;
        end
        if (dec_phase == P_IDLE)
        begin
            if (lvl > lim)
                err = ERR_DEPTH;
            else if (b <= TAG_FIXINT_MAX)
            begin
                r.kind = KIND_SCALAR; r.value_type = VT_UINT; r.value_bits = {56'd0, b};
                r.top_value_done = finish_value();
            end
            else if (b >= TAG_NEG_FIXINT)
            begin
                r.kind = KIND_SCALAR; r.value_type = VT_INT;
                r.value_bits = {{56{1'b1}}, b};
                r.top_value_done = finish_value();
            end
            else if (b[7:5] == 3'b101)
            begin
                r.kind = KIND_STR_START; r.value_type = VT_STR;
                r.value_bits = {59'd0, b[4:0]};
                if (b[4:0] == 0)
                    r.top_value_done = finish_value();
                else
                begin
                    dec_tag = b; dec_left = {27'd0, b[4:0]}; dec_phase = P_PAYLOAD;
                end
            end
            else if (b[7:4] == 4'h8)
            begin
                r.kind = KIND_OPEN; r.value_type = VT_MAP; r.value_bits = {60'd0, b[3:0]};
                r.top_value_done = open_children({28'd0, b[3:0], 1'b0}, lvl);
            end
            else if (b[7:4] == 4'h9)
            begin
                r.kind = KIND_OPEN; r.value_type = VT_ARRAY; r.value_bits = {60'd0, b[3:0]};
                r.top_value_done = open_children({29'd0, b[3:0]}, lvl);
            end
            else if (b == TAG_NIL)
            begin
                r.kind = KIND_SCALAR; r.value_type = VT_NIL;
                r.top_value_done = finish_value();
            end
            else if (b == TAG_FALSE || b == TAG_TRUE)
            begin
                r.kind = KIND_SCALAR; r.value_type = VT_BOOL; r.value_bits = {63'd0, b[0]};
                r.top_value_done = finish_value();
            end
            else
            begin
                n = 0;
                ph = P_SCALAR;
                if (b >= TAG_BIN8 && b <= TAG_BIN32)
                begin
                    n = 1 << (b - TAG_BIN8); ph = P_LEN;
                end
                else if (b >= TAG_STR8 && b <= TAG_STR32)
                begin
                    n = 1 << (b - TAG_STR8); ph = P_LEN;
                end
                else if (b == TAG_FLOAT32)
                    n = 4;
                else if (b == TAG_FLOAT64)
                    n = 8;
                else if (b >= TAG_UINT8 && b <= TAG_INT64)
                    n = 1 << (b[1:0]);
                else if (b == TAG_ARRAY16 || b == TAG_MAP16)
                begin
                    n = 2; ph = P_COUNT;
                end
                else if (b == TAG_ARRAY32 || b == TAG_MAP32)
                begin
                    n = 4; ph = P_COUNT;
                end
                if (n == 0)
                    err = ERR_TAG;
                else
                begin
                    r.kind = KIND_HEADER; r.value_type = tag_type(b);
                    dec_tag = b; dec_gather = '0; dec_left = 32'(n); dec_phase = ph;
                end
            end
        end
        else if (dec_phase == P_PAYLOAD)
        begin
            r.kind = KIND_PAYLOAD; r.value_type = tag_type(dec_tag); r.payload_byte = b;
            dec_left--;
            if (dec_left == 0)
            begin
                r.last_payload = 1'b1;
                dec_phase = P_IDLE;
                r.top_value_done = finish_value();
            end
        end
        else
        begin
            r.value_type = tag_type(dec_tag);
            dec_gather = {dec_gather[55:0], b};
            dec_left--;
            if (dec_left != 0)
                r.kind = KIND_HEADER;
            else if (dec_phase == P_SCALAR)
            begin
                dec_phase = P_IDLE;
                r.kind = KIND_SCALAR;
                if (dec_tag == TAG_FLOAT32)
                    r.value_bits = f32_to_f64(dec_gather[31:0]);
                else if (dec_tag == 8'hD0)
                    r.value_bits = 64'(signed'(dec_gather[7:0]));
                else if (dec_tag == 8'hD1)
                    r.value_bits = 64'(signed'(dec_gather[15:0]));
                else if (dec_tag == 8'hD2)
                    r.value_bits = 64'(signed'(dec_gather[31:0]));
                else
                    r.value_bits = dec_gather;
                r.top_value_done = finish_value();
            end
            else if (dec_phase == P_LEN)
            begin
                r.kind = KIND_STR_START; r.value_bits = {32'd0, dec_gather[31:0]};
                if (dec_gather[31:0] == 0)
                begin
                    dec_phase = P_IDLE;
                    r.top_value_done = finish_value();
                end
                else
                begin
                    dec_left = dec_gather[31:0]; dec_phase = P_PAYLOAD;
                end
            end
            else
            begin
                dec_phase = P_IDLE;
                r.kind = KIND_OPEN; r.value_bits = {32'd0, dec_gather[31:0]};
                r.top_value_done = open_children(r.value_type == VT_MAP ?
                    {dec_gather[31:0], 1'b0} : {1'b0, dec_gather[31:0]}, lvl);
            end
        end
        if (err == ERR_NONE && last_byte && (dec_phase != P_IDLE || dec_level != 0))
            err = ERR_TRUNC;
        if (err != ERR_NONE)
        begin
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = err;
            lvl = dec_level;
            dec_error = 1'b1;
        end
        if (last_byte)
            clear_decoder();
        r.nest_level = lvl;
        return r;
    endfunction

    // Send one item; valid stays high on return.
    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{data_byte: b, buffer_end: last_byte};
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_tokens.push_back(decode_byte(b, last_byte));
    endtask

    task automatic send_buffer();
        foreach (byte_seq[i])
            send_byte(byte_seq[i], i == byte_seq.size() - 1);
        byte_seq.delete();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        dec_limit = (CFG_INDEX == 0) ? v : dec_limit;
        cfg_we    <= 1'b0;
    endtask

    function automatic void push_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            byte_seq.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Append one well-formed value with random content.
    function automatic void gen_value(input int depth);
        int sel;
        int n;
        int len;
        sel = $urandom_range(depth > 4 ? 8 : 12);
        case (sel)
            0: byte_seq.push_back(8'($urandom_range(8'h7F)));
            1: byte_seq.push_back(8'($urandom_range(8'hFF, 8'hE0)));
            2: byte_seq.push_back($urandom_range(1) ? TAG_NIL
                                                    : 8'(TAG_FALSE + $urandom_range(1)));
            3, 4:
            begin
                byte_seq.push_back(8'($urandom_range(8'hD3, 8'hCC)));
                push_be(rand64(), 1 << byte_seq[$][1:0]);
            end
            5:
            begin
                byte_seq.push_back(TAG_FLOAT32);
                push_be(rand64() >> ($urandom_range(1) ? 0 : $urandom_range(31)), 4);
            end
            6:
            begin
                byte_seq.push_back(TAG_FLOAT64);
                push_be(rand64(), 8);
            end
            7:
            begin
                len = $urandom_range(4);
                byte_seq.push_back(TAG_FIXSTR | 8'(len));
                repeat (len) byte_seq.push_back(8'($urandom_range(255)));
            end
            8:
            begin
                len = $urandom_range(3);
                n = $urandom_range(2);
                byte_seq.push_back(8'(($urandom_range(1) ? TAG_STR8 : TAG_BIN8) + n));
                push_be(64'(len), 1 << n);
                repeat (len) byte_seq.push_back(8'($urandom_range(255)));
            end
            9, 10:
            begin
                len = $urandom_range(3);
                byte_seq.push_back((sel == 9 ? TAG_FIXARRAY : TAG_FIXMAP) | 8'(len));
                repeat (sel == 9 ? len : 2 * len) gen_value(depth + 1);
            end
            default:
            begin
                len = $urandom_range(2);
                n = $urandom_range(1);
                byte_seq.push_back(8'((sel == 11 ? TAG_ARRAY16 : TAG_MAP16) + n));
                push_be(64'(len), n ? 4 : 2);
                repeat (sel == 11 ? len : 2 * len) gen_value(depth + 1);
            end
        endcase
    endfunction

    // Check each result against the oldest expectation.
    always @(posedge clk)
    begin
        msp_out_t got;
        msp_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_tokens.size() == 0)
                report_mismatch("unexpected item", got.value_bits, '0);
            else
            begin
                want = expected_tokens.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("kind", got.kind, want.kind);
                if (got.value_type != want.value_type)
                    report_mismatch("value_type", got.value_type, want.value_type);
                if (got.value_bits != want.value_bits)
                    report_mismatch("value_bits", got.value_bits, want.value_bits);
                if (got.payload_byte != want.payload_byte)
                    report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
                if (got.last_payload != want.last_payload)
                    report_mismatch("last_payload", got.last_payload, want.last_payload);
                if (got.nest_level != want.nest_level)
                    report_mismatch("nest_level", got.nest_level, want.nest_level);
                if (got.top_value_done != want.top_value_done)
                    report_mismatch("top_value_done", got.top_value_done,
                                    want.top_value_done);
                if (got.error_code != want.error_code)
                    report_mismatch("error_code", got.error_code, want.error_code);
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** msgpack_stream_parser_unit: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic test_scalars();
        byte_seq = '{8'h00, 8'h7F, 8'hE0, 8'hFF, TAG_NIL, TAG_FALSE, TAG_TRUE,
                     TAG_UINT64, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     TAG_INT64, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_buffer();
        // float32: smallest subnormal, NaN payload, negative infinity, negative subnormal
        byte_seq = '{TAG_FLOAT32, 8'h00, 8'h00, 8'h00, 8'h01,
                     TAG_FLOAT32, 8'h7F, 8'hC0, 8'h00, 8'h01,
                     TAG_FLOAT32, 8'hFF, 8'h80, 8'h00, 8'h00,
                     TAG_FLOAT32, 8'h80, 8'h40, 8'h00, 8'h00};
        send_buffer();
    endtask

    task automatic test_containers();
        // empty string, empty array, empty map, nested array with payload and map, empty map16
        byte_seq = '{TAG_FIXSTR, TAG_FIXARRAY, TAG_FIXMAP, 8'h92, 8'h91, 8'hA2, 8'h41,
                     8'h42, 8'h81, TAG_BIN8, 8'h00, 8'hC3, TAG_MAP16, 8'h00, 8'h00};
        send_buffer();
        // map32 with a huge pair count, cut short by the buffer end
        byte_seq = '{TAG_MAP32, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01};
        send_buffer();
    endtask

    task automatic test_errors();
        byte_seq = '{8'hC1, 8'h05, 8'h90};
        send_buffer();
        byte_seq = '{8'hC7};
        send_buffer();
        byte_seq = '{8'hD8, 8'h01};
        send_buffer();
        byte_seq = '{TAG_INT8 + 8'd1, 8'h12};
        send_buffer();
        // depth above a zero limit
        write_limit(4'd0);
        byte_seq = '{8'h91, 8'h01, 8'h02};
        send_buffer();
        // limit above the parameter acts as the parameter
        write_limit(4'd15);
        repeat (9) byte_seq.push_back(8'h91);
        byte_seq.push_back(8'h00);
        byte_seq.push_back(8'h00);
        send_buffer();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int items,
                               input logic [3:0] limit);
        int sent;
        int cut;
        write_limit(limit);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            repeat ($urandom_range(1, 3)) gen_value(0);
            case ($urandom_range(9))
                0:
                begin
                    // truncated buffer
                    cut = $urandom_range(1, byte_seq.size());
                    while (byte_seq.size() > cut)
                        void'(byte_seq.pop_back());
                end
                1: byte_seq.insert($urandom_range(byte_seq.size() - 1),
                                   8'($urandom_range(255)));
                2: wait_drained();
                default: ;
            endcase
            sent += byte_seq.size();
            send_buffer();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        dec_limit = 4'd8;
        clear_decoder();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scalars();
        test_containers();
        test_errors();
        test_random(0, 0, 90, 4'd8);
        test_random(75, 0, 90, 4'd10);
        test_random(0, 75, 90, 4'd3);
        test_random(14, 14, 90, 4'd5);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** msgpack_stream_parser_unit: PASSED **");
        else
            $display("** msgpack_stream_parser_unit: FAILED **");
        $finish;
    end

endmodule
